// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ----- rtl/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, codes and constant tables of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef logic [31:0]     word_type;
   typedef word_type [7:0]  hash_type;   // [0] is a (most significant digest word)

   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
   localparam int LEN_BYTES   = 8;

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_FINISH  = 2'd1,
      KIND_RESTART = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   localparam hash_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type ror32(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- rtl/sha256_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_round
// One compression round and one message schedule word, shared by all rounds.
// ----------------------------------------------------------------------------
module sha256_round (
   input  logic [5:0]           round_idx,
   input  sha256_pkg::hash_type v_cur,
   input  sha256_pkg::word_type w_t,     // W[t]
   input  sha256_pkg::word_type w_t1,    // W[t+1]
   input  sha256_pkg::word_type w_t9,    // W[t+9]
   input  sha256_pkg::word_type w_t14,   // W[t+14]
   output sha256_pkg::hash_type v_next,
   output sha256_pkg::word_type w_new    // W[t+16]
);
   import sha256_pkg::*;

   word_type big_s0;
   word_type big_s1;
   word_type ch;
   word_type maj;
   word_type t1;
   word_type t2;
   word_type small_s0;
   word_type small_s1;

   always_comb begin
      big_s1 = ror32(v_cur[4], 6) ^ ror32(v_cur[4], 11) ^ ror32(v_cur[4], 25);
      ch     = (v_cur[4] & v_cur[5]) ^ (~v_cur[4] & v_cur[6]);
      t1     = v_cur[7] + big_s1 + ch + K_TABLE[round_idx] + w_t;
      big_s0 = ror32(v_cur[0], 2) ^ ror32(v_cur[0], 13) ^ ror32(v_cur[0], 22);
      maj    = (v_cur[0] & v_cur[1]) ^ (v_cur[0] & v_cur[2]) ^ (v_cur[1] & v_cur[2]);
      t2     = big_s0 + maj;

      v_next[7] = v_cur[6];
      v_next[6] = v_cur[5];
      v_next[5] = v_cur[4];
      v_next[4] = v_cur[3] + t1;
      v_next[3] = v_cur[2];
      v_next[2] = v_cur[1];
      v_next[1] = v_cur[0];
      v_next[0] = t1 + t2;

      // Schedule expansion; words produced in the last rounds are never used.
      small_s0 = ror32(w_t1, 7) ^ ror32(w_t1, 18) ^ (w_t1 >> 3);
      small_s1 = ror32(w_t14, 17) ^ ror32(w_t14, 19) ^ (w_t14 >> 10);
      w_new    = w_t + small_s0 + w_t9 + small_s1;
   end

endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: gathers 64-byte blocks, pads at finish and
// returns the eight digest words as beats.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   req     | in        | req_valid/req_stall | req_kind, req_data_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_digest_word, rsp_word_index,
//           |           |                     | rsp_last_word
//
// A data byte, restart or ignored beat is taken whenever the block is idle. The
// byte that fills a block starts 64 rounds through the single shared round unit,
// then a final step folds the working words into the hash words.
// A finish first shifts in pad bytes at one per cycle (64 or 128 minus the bytes
// held), compresses once or twice, then holds eight digest beats.
// A repeated finish goes straight to the eight digest beats.
// Reset is synchronous, active high; it loads the initial hash words and
// clears the counters. req_stall is high whenever the block is not idle;
// rsp_stall holds the current digest beat in place.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha256_pkg::*;

`include "assert_macros.svh"

   localparam int SCHED_W = BLOCK_BITS;
   localparam logic [5:0] LEN_POS_PRE = 6'(BLOCK_BYTES - LEN_BYTES - 1);

   state_type            state_ff, state_in;
   hash_type             hash_ff, hash_in;
   hash_type             v_ff, v_in;
   logic [SCHED_W-1:0]   sched_ff, sched_in;     // block bytes, then W[t..t+15]
   logic [5:0]           count_ff, count_in;     // bytes in block
   logic [5:0]           round_ff, round_in;
   logic [63:0]          bits_ff, bits_in;       // message bit length
   logic                 finished_ff, finished_in;
   logic                 finishing_ff, finishing_in;
   logic                 pad_first_ff, pad_first_in;
   logic                 pad_len_ff, pad_len_in;
   logic [2:0]           idx_ff, idx_in;

   hash_type             v_next;
   word_type             w_new;
   logic [7:0]           pad_byte;

   sha256_round u_round (
      .round_idx (round_ff),
      .v_cur     (v_ff),
      .w_t       (sched_ff[511:480]),
      .w_t1      (sched_ff[479:448]),
      .w_t9      (sched_ff[223:192]),
      .w_t14     (sched_ff[63:32]),
      .v_next    (v_next),
      .w_new     (w_new)
   );

   // Marker first, then zero fill, then the length big-endian.
   assign pad_byte = pad_first_ff ? PAD_MARK : (pad_len_ff ? bits_ff[63:56] : 8'h00);

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= HASH_INIT;
         count_ff     <= '0;
         round_ff     <= '0;
         bits_ff      <= '0;
         finished_ff  <= 1'b0;
         finishing_ff <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_len_ff   <= 1'b0;
         idx_ff       <= '0;
      end else begin
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         bits_ff      <= bits_in;
         finished_ff  <= finished_in;
         finishing_ff <= finishing_in;
         pad_first_ff <= pad_first_in;
         pad_len_ff   <= pad_len_in;
         idx_ff       <= idx_in;
      end
   end

   // Working words and the block line carry payload only.
   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      sched_ff <= sched_in;
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      v_in         = v_ff;
      sched_in     = sched_ff;
      count_in     = count_ff;
      round_in     = round_ff;
      bits_in      = bits_ff;
      finished_in  = finished_ff;
      finishing_in = finishing_ff;
      pad_first_in = pad_first_ff;
      pad_len_in   = pad_len_ff;
      idx_in       = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_DATA: begin
                     // Drop data after a finish.
                     if (!finished_ff) begin
                        sched_in = {sched_ff[SCHED_W-9:0], req_data_byte};
                        count_in = count_ff + 6'd1;
                        if (count_ff == '1) begin
                           bits_in      = bits_ff + 64'(BLOCK_BITS);
                           v_in         = hash_ff;
                           round_in     = '0;
                           finishing_in = 1'b0;
                           state_in     = ST_ROUND;
                        end
                     end
                  end
                  KIND_FINISH: begin
                     if (finished_ff) begin
                        idx_in   = '0;
                        state_in = ST_EMIT;
                     end else begin
                        bits_in      = bits_ff + 64'({count_ff, 3'b000});
                        pad_first_in = 1'b1;
                        pad_len_in   = 1'b0;
                        finishing_in = 1'b1;
                        state_in     = ST_PAD;
                     end
                  end
                  KIND_RESTART: begin
                     hash_in     = HASH_INIT;
                     count_in    = '0;
                     bits_in     = '0;
                     finished_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_PAD: begin
            sched_in     = {sched_ff[SCHED_W-9:0], pad_byte};
            count_in     = count_ff + 6'd1;
            pad_first_in = 1'b0;
            if (pad_len_ff) begin
               bits_in = {bits_ff[55:0], 8'h00};
            end
            // The byte after this one opens the length field.
            if (count_ff == LEN_POS_PRE) begin
               pad_len_in = 1'b1;
            end
            if (count_ff == '1) begin
               v_in     = hash_ff;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            v_in     = v_next;
            sched_in = {sched_ff[SCHED_W-33:0], w_new};
            round_in = round_ff + 6'd1;
            if (round_ff == '1) begin
               state_in = ST_FINAL;
            end
         end

         ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            if (!finishing_ff) begin
               state_in = ST_IDLE;
            end else if (pad_len_ff) begin
               finishing_in = 1'b0;
               finished_in  = 1'b1;
               count_in     = '0;
               idx_in       = '0;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end

         ST_EMIT: begin
            // Hold the beat while stalled; advance on each taken word.
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == '1) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // No request is taken while digest beats are pending.
   `ASSERT_IMPLIES(a_no_req_during_emit, clock, reset, rsp_valid, req_stall)
   // The last digest beat closes the response.
   `ASSERT_NEXT(a_last_beat_ends, clock, reset,
                rsp_valid && !rsp_stall && rsp_last_word, !rsp_valid)
   // Every compression starts at round zero.
   `ASSERT_IMPLIES(a_round_start, clock, reset,
                   state_ff == ST_ROUND && $past(state_ff) != ST_ROUND, round_ff == '0)
   // A finished message holds no partial block.
   `ASSERT_IMPLIES(a_finished_empty, clock, reset, finished_ff, count_ff == '0)

endmodule
